// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the volume envelope block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// check that a condition in one cycle forces a result in the next
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/adsr_pkg.sv =====
// Types, register indexes and effect codes of the volume envelope block
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int unsigned CfgAddrWidth = 5;

    localparam logic [2:0] REG_ATTACK_MAX    = 3'd0;
    localparam logic [2:0] REG_ATTACK_SPEED  = 3'd1;
    localparam logic [2:0] REG_DECAY_FLOOR   = 3'd2;
    localparam logic [2:0] REG_DECAY_SPEED   = 3'd3;
    localparam logic [2:0] REG_SUSTAIN_TICKS = 3'd4;
    localparam logic [2:0] REG_RELEASE_FLOOR = 3'd5;
    localparam logic [2:0] REG_RELEASE_SPEED = 3'd6;

    localparam logic [7:0] EFF_VOL_UP   = 8'h73;
    localparam logic [7:0] EFF_VOL_DOWN = 8'h74;
    localparam logic [7:0] EFF_SET_VOL  = 8'h7c;

    localparam logic [2:0] PH_CODE_ATTACK  = 3'd4;
    localparam logic [2:0] PH_CODE_DECAY   = 3'd3;
    localparam logic [2:0] PH_CODE_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_CODE_RELEASE = 3'd1;
    localparam logic [2:0] PH_CODE_DONE    = 3'd0;

    typedef enum logic [4:0] {
        PH_DONE    = 5'b00001,
        PH_RELEASE = 5'b00010,
        PH_SUSTAIN = 5'b00100,
        PH_DECAY   = 5'b01000,
        PH_ATTACK  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       opcode;
        logic       later_tick;
        logic [7:0] effect_code;
        logic [7:0] effect_param;
        logic       has_instrument;
    } in_item_t;

    typedef struct packed {
        logic signed [8:0] channel_volume;
        logic [2:0]        envelope_phase;
    } out_item_t;

    typedef struct packed {
        logic [7:0] attack_max;
        logic [7:0] attack_speed;
        logic [7:0] decay_floor;
        logic [7:0] decay_speed;
        logic [7:0] sustain_ticks;
        logic [7:0] release_floor;
        logic [7:0] release_speed;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic signed [8:0] level;
        logic [7:0]        hold_count;
    } env_state_t;

    function automatic logic [2:0] phase_code(phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_ATTACK:  code = PH_CODE_ATTACK;
            PH_DECAY:   code = PH_CODE_DECAY;
            PH_SUSTAIN: code = PH_CODE_SUSTAIN;
            PH_RELEASE: code = PH_CODE_RELEASE;
            default:    code = PH_CODE_DONE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/adsr_volume_envelope.sv =====
// Top level of the volume envelope block: item registers, state and APB port
//
//   port group   direction   carries
//   s_*          in          one tick item per handshake
//   m_*          out         channel volume and phase for each tick
//   p*           in/out      APB access to the seven shape registers
//
// A tick item is taken into the input register, and its result then lands in
// the output register; one item per cycle is sustained while m_ready is high.
// The state update and result come from a single add, compare and clamp path.
// Reset is synchronous on aresetn and clears state, shape registers and valids.
// A stalled m_ready holds the result; s_ready drops only when both registers are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adsr_volume_envelope (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  adsr_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output adsr_pkg::out_item_t              m_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adsr_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    adsr_pkg::cfg_t       cfg;
    adsr_pkg::in_item_t   in_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    adsr_pkg::out_item_t  out_reg;
    adsr_pkg::out_item_t  out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    adsr_pkg::env_state_t state_reg;
    adsr_pkg::env_state_t state_next;
    logic                 advance;
    logic                 in_take;

    adsr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adsr_step u_step (
        .cfg    (cfg),
        .cur    (state_reg),
        .item   (in_reg),
        .nxt    (state_next),
        .result (out_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.phase  <= adsr_pkg::PH_DONE;
            state_reg.level  <= '0;
            state_reg.hold_count <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    `ASSERT_NEXT(a_advance_shows, advance, m_valid)
    `ASSERT_NEXT(a_state_holds, !advance, $stable(state_reg))
    `ASSERT_CLK(a_neg_volume, !(m_valid && m_item.channel_volume[8]) || (m_item.channel_volume == -9'sd1))
    `ASSERT_CLK(a_phase_onehot, $onehot(state_reg.phase))

endmodule

// ===== rtl/core/adsr_cfg_regs.sv =====
// APB register file holding the envelope shape settings
`timescale 1ns / 1ps

module adsr_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adsr_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output adsr_pkg::cfg_t                   cfg
);

    adsr_pkg::cfg_t cfg_reg;
    adsr_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic [7:0]     rd_byte;
    logic           wr_en;

    assign reg_idx = paddr[adsr_pkg::CfgAddrWidth-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                adsr_pkg::REG_ATTACK_MAX:    cfg_next.attack_max    = pwdata[7:0];
                adsr_pkg::REG_ATTACK_SPEED:  cfg_next.attack_speed  = pwdata[7:0];
                adsr_pkg::REG_DECAY_FLOOR:   cfg_next.decay_floor   = pwdata[7:0];
                adsr_pkg::REG_DECAY_SPEED:   cfg_next.decay_speed   = pwdata[7:0];
                adsr_pkg::REG_SUSTAIN_TICKS: cfg_next.sustain_ticks = pwdata[7:0];
                adsr_pkg::REG_RELEASE_FLOOR: cfg_next.release_floor = pwdata[7:0];
                adsr_pkg::REG_RELEASE_SPEED: cfg_next.release_speed = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            adsr_pkg::REG_ATTACK_MAX:    rd_byte = cfg_reg.attack_max;
            adsr_pkg::REG_ATTACK_SPEED:  rd_byte = cfg_reg.attack_speed;
            adsr_pkg::REG_DECAY_FLOOR:   rd_byte = cfg_reg.decay_floor;
            adsr_pkg::REG_DECAY_SPEED:   rd_byte = cfg_reg.decay_speed;
            adsr_pkg::REG_SUSTAIN_TICKS: rd_byte = cfg_reg.sustain_ticks;
            adsr_pkg::REG_RELEASE_FLOOR: rd_byte = cfg_reg.release_floor;
            adsr_pkg::REG_RELEASE_SPEED: rd_byte = cfg_reg.release_speed;
            default:                     rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/adsr_step.sv =====
// One envelope tick: phase step, row effects and channel volume
`timescale 1ns / 1ps

module adsr_step (
    input  adsr_pkg::cfg_t       cfg,
    input  adsr_pkg::env_state_t cur,
    input  adsr_pkg::in_item_t   item,
    output adsr_pkg::env_state_t nxt,
    output adsr_pkg::out_item_t  result
);

    always_comb begin
        adsr_pkg::phase_t  ph;
        logic signed [8:0] lv;
        logic [7:0]        hc;
        logic signed [10:0] lvw;
        logic signed [10:0] sum;
        logic signed [11:0] base;
        logic signed [11:0] adj;
        logic signed [11:0] p4;
        logic signed [8:0] vol;

        ph  = cur.phase;
        lv  = cur.level;
        hc  = cur.hold_count;
        sum = '0;
        base = '0;
        adj = '0;

        if (item.opcode) begin
            ph = adsr_pkg::PH_ATTACK;
            lv = '0;
            hc = '0;
        end

        lvw = {{2{lv[8]}}, lv};

        unique case (ph)
            adsr_pkg::PH_ATTACK: begin
                sum = lvw + $signed({3'b000, cfg.attack_speed});
                if (sum >= $signed({3'b000, cfg.attack_max})) begin
                    lv = $signed({1'b0, cfg.attack_max});
                    ph = adsr_pkg::PH_DECAY;
                end else begin
                    lv = sum[8:0];
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (cfg.decay_speed == 8'd0) begin
                    ph = adsr_pkg::PH_SUSTAIN;
                end else begin
                    sum = lvw - $signed({3'b000, cfg.decay_speed});
                    if (sum <= $signed({3'b000, cfg.decay_floor})) begin
                        lv = $signed({1'b0, cfg.decay_floor});
                        ph = adsr_pkg::PH_SUSTAIN;
                    end else begin
                        lv = sum[8:0];
                    end
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                if (hc == cfg.sustain_ticks) begin
                    ph = adsr_pkg::PH_RELEASE;
                end else begin
                    hc = hc + 8'd1;
                end
            end
            adsr_pkg::PH_RELEASE: begin
                sum = lvw - $signed({3'b000, cfg.release_speed});
                if (sum <= $signed({3'b000, cfg.release_floor})) begin
                    lv = $signed({1'b0, cfg.release_floor});
                    ph = adsr_pkg::PH_DONE;
                end else begin
                    lv = sum[8:0];
                end
            end
            default: begin
                ph = cur.phase;
            end
        endcase

        vol = lv >>> 2;

        // slide the level once the envelope is done
        p4 = $signed({2'b00, item.effect_param, 2'b00});
        if (item.later_tick && ph == adsr_pkg::PH_DONE) begin
            base = item.has_instrument ? $signed({4'b0000, cfg.attack_max})
                                       : {{3{lv[8]}}, lv};
            if (item.effect_code == adsr_pkg::EFF_VOL_UP) begin
                adj = base + p4;
                lv  = (adj >= 12'sd256) ? -9'sd1 : adj[8:0];
            end else if (item.effect_code == adsr_pkg::EFF_VOL_DOWN) begin
                adj = base - p4;
                lv  = (adj < 12'sd0) ? 9'sd0 : adj[8:0];
            end
        end

        if (item.effect_code == adsr_pkg::EFF_SET_VOL) begin
            vol = $signed({1'b0, item.effect_param});
            lv  = (item.effect_param[7:6] != 2'b00) ? 9'sd255
                                                   : $signed({1'b0, item.effect_param[5:0], 2'b00});
        end

        nxt.phase      = ph;
        nxt.level      = lv;
        nxt.hold_count = hc;
        result.channel_volume = vol;
        result.envelope_phase = adsr_pkg::phase_code(ph);
    end

endmodule
